// ----- rtl/core/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, codes and helpers for the JSON string unescape core.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Decoder phase.
    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_BODY = 4'd1,
        PH_ESC  = 4'd2,
        PH_HEX1 = 4'd3,
        PH_BSL  = 4'd4,
        PH_LOWU = 4'd5,
        PH_HEX2 = 4'd6
    } t_phase;

    // Result kind.
    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_DONE = 2'd1,
        K_ERR  = 2'd2
    } t_kind;

    // Error codes.
    typedef enum logic [3:0] {
        E_NO_QUOTE     = 4'd0,
        E_CTRL_CHAR    = 4'd1,
        E_SHORT_ESC    = 4'd2,
        E_UNKNOWN_ESC  = 4'd3,
        E_SHORT_UNI    = 4'd4,
        E_BAD_HEX      = 4'd5,
        E_NO_LOW       = 4'd6,
        E_BAD_LOW      = 4'd7,
        E_LONE_LOW     = 4'd8,
        E_UNTERMINATED = 4'd9
    } t_err;

    localparam int MAX_RESULTS = 4;

    // Characters of interest.
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LN    = 8'h6E;
    localparam logic [7:0] CH_LR    = 8'h72;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_LU    = 8'h75;

    // Input transaction.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_end;
    } t_in;

    // Output transaction.
    typedef struct packed {
        t_kind      out_kind;
        logic [7:0] out_byte;
        t_err       error_code;
        logic       last;
    } t_out;

    // All results caused by one input, first byte in bytes[0].
    typedef struct packed {
        logic [2:0]                    count;
        t_kind                         kind;
        t_err                          err;
        logic [MAX_RESULTS-1:0][7:0]   bytes;
    } t_burst;

    function automatic t_burst f_burst_none();
        t_burst r;
        r.count = 3'd0;
        r.kind  = K_BYTE;
        r.err   = E_NO_QUOTE;
        r.bytes = '0;
        return r;
    endfunction

    function automatic t_burst f_burst_byte(logic [7:0] b);
        t_burst r;
        r          = f_burst_none();
        r.count    = 3'd1;
        r.bytes[0] = b;
        return r;
    endfunction

    function automatic t_burst f_burst_done();
        t_burst r;
        r       = f_burst_none();
        r.count = 3'd1;
        r.kind  = K_DONE;
        return r;
    endfunction

    function automatic t_burst f_burst_err(t_err e);
        t_burst r;
        r       = f_burst_none();
        r.count = 3'd1;
        r.kind  = K_ERR;
        r.err   = e;
        return r;
    endfunction

    // UTF-8 encode of a code point up to 21 bits.
    function automatic t_burst f_utf8(logic [20:0] cp);
        t_burst r;
        r = f_burst_none();
        if (cp <= 21'h7F) begin
            r.count    = 3'd1;
            r.bytes[0] = cp[7:0];
        end else if (cp <= 21'h7FF) begin
            r.count    = 3'd2;
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
        end else if (cp <= 21'hFFFF) begin
            r.count    = 3'd3;
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
        end else begin
            r.count    = 3'd4;
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/json_string_unescape_core.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Decodes a JSON string token byte by byte into raw UTF-8 bytes, a done mark
// or a single error code.
// ----------------------------------------------------------------------------
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------
//  in      | in  | i_in_valid / o_in_stall | i_in_item  (in_byte, in_end)
//  out     | out | o_out_valid / i_out_stall | o_out_item (kind, byte, err, last)
//
//  One input byte per cycle while o_in_stall is low. The decoder state machine
//  works on the byte at the port and writes its whole burst (0 to 4 results)
//  into the result register in the same cycle; results leave in order, and a
//  \uXXXX giving 2 to 4 UTF-8 bytes holds the input until the last is taken.
//  Reset (synchronous, active low) returns to idle awaiting the quote and
//  empties the result register.
//  o_in_stall is high while a burst is pending and its last result is not
//  being taken in this cycle; inputs that produce no result still need a free
//  result register.
// ----------------------------------------------------------------------------
module json_string_unescape_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  jsu_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output jsu_pkg::t_out o_out_item
);
    import jsu_pkg::*;

    t_burst burst;      // results caused by the byte at the port
    logic   free;       // result register empty, or emptied this cycle
    logic   in_take;    // input transaction completes

    assign o_in_stall = !free;
    assign in_take    = i_in_valid && free;

    // State machine: phase, hex accumulation, surrogate high half.
    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (in_take),
        .i_item  (i_in_item),
        .o_burst (burst)
    );

    // Result register and serializer.
    jsu_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (in_take),
        .i_burst (burst),
        .o_free  (free),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_item  (o_out_item)
    );

    // Input is only held off by a pending burst.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result register");

    // Done and error are always the final result of their byte.
    a_ctrl_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.out_kind != K_BYTE) |-> o_out_item.last)
        else $error("done/error result not marked last");

    // A burst never stops short of its last result.
    a_burst_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !o_out_item.last) |=> o_out_valid)
        else $error("burst dropped before its last result");

    // Kind code 3 is never produced.
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.out_kind == K_BYTE || o_out_item.out_kind == K_DONE ||
                         o_out_item.out_kind == K_ERR))
        else $error("undefined result kind");

endmodule

// ----- rtl/core/jsu_decode.sv -----
// ----------------------------------------------------------------------------
// jsu_decode
// Escape decoder state machine; turns one input byte into a result burst.
// ----------------------------------------------------------------------------
module jsu_decode (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_take,
    input  jsu_pkg::t_in   i_item,
    output jsu_pkg::t_burst o_burst
);
    import jsu_pkg::*;

    t_phase      r_phase,     n_phase;
    logic [15:0] r_code_unit, n_code_unit;
    logic [9:0]  r_high_half, n_high_half;
    logic [1:0]  r_hex_count, n_hex_count;

    logic [7:0]  b;
    logic        fin;
    logic        hex_ok;
    logic [3:0]  hex_val;
    logic [15:0] cu_shift;
    logic        hi_sur;
    logic        lo_sur;
    logic        is_ws;
    logic [20:0] pair_cp;

    assign b   = i_item.in_byte;
    assign fin = i_item.in_end;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            hex_val = b[3:0];
        end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
            hex_val = b[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign cu_shift = {r_code_unit[11:0], hex_val};
    assign hi_sur   = (cu_shift[15:10] == 6'b110110);
    assign lo_sur   = (cu_shift[15:10] == 6'b110111);
    assign is_ws    = (b == CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    assign pair_cp  = 21'h10000 + {1'b0, r_high_half, cu_shift[9:0]};

    // Next state.
    always_comb begin
        n_phase     = r_phase;
        n_code_unit = r_code_unit;
        n_high_half = r_high_half;
        n_hex_count = r_hex_count;
        case (r_phase)
            PH_BODY: begin
                if (fin || b == CH_QUOTE || b < CH_SPACE) begin
                    n_phase = PH_IDLE;
                end else if (b == CH_BSL) begin
                    n_phase = PH_ESC;
                end
            end
            PH_ESC: begin
                if (fin) begin
                    n_phase = PH_IDLE;
                end else if (b == CH_LU) begin
                    n_phase     = PH_HEX1;
                    n_code_unit = 16'd0;
                    n_hex_count = 2'd0;
                end else if (b == CH_QUOTE || b == CH_BSL || b == CH_SLASH || b == CH_LB ||
                             b == CH_LF || b == CH_LN || b == CH_LR || b == CH_LT) begin
                    n_phase = PH_BODY;
                end else begin
                    n_phase = PH_IDLE;
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (fin || !hex_ok) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_code_unit = cu_shift;
                    if (r_hex_count != 2'd3) begin
                        n_hex_count = r_hex_count + 2'd1;
                    end else begin
                        n_hex_count = 2'd0;
                        if (r_phase == PH_HEX1) begin
                            if (hi_sur) begin
                                n_high_half = cu_shift[9:0];
                                n_phase     = PH_BSL;
                            end else if (lo_sur) begin
                                n_phase = PH_IDLE;
                            end else begin
                                n_phase = PH_BODY;
                            end
                        end else begin
                            n_phase = lo_sur ? PH_BODY : PH_IDLE;
                        end
                    end
                end
            end
            PH_BSL: begin
                n_phase = (fin || b != CH_BSL) ? PH_IDLE : PH_LOWU;
            end
            PH_LOWU: begin
                if (fin || b != CH_LU) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_phase     = PH_HEX2;
                    n_code_unit = 16'd0;
                    n_hex_count = 2'd0;
                end
            end
            default: begin
                n_phase = (!fin && b == CH_QUOTE) ? PH_BODY : PH_IDLE;
            end
        endcase
    end

    // Results for the current byte.
    always_comb begin
        o_burst = f_burst_none();
        case (r_phase)
            PH_BODY: begin
                if (fin) begin
                    o_burst = f_burst_err(E_UNTERMINATED);
                end else if (b == CH_QUOTE) begin
                    o_burst = f_burst_done();
                end else if (b < CH_SPACE) begin
                    o_burst = f_burst_err(E_CTRL_CHAR);
                end else if (b != CH_BSL) begin
                    o_burst = f_burst_byte(b);
                end
            end
            PH_ESC: begin
                if (fin) begin
                    o_burst = f_burst_err(E_SHORT_ESC);
                end else if (b == CH_QUOTE || b == CH_BSL || b == CH_SLASH) begin
                    o_burst = f_burst_byte(b);
                end else if (b == CH_LB) begin
                    o_burst = f_burst_byte(8'h08);
                end else if (b == CH_LF) begin
                    o_burst = f_burst_byte(8'h0C);
                end else if (b == CH_LN) begin
                    o_burst = f_burst_byte(8'h0A);
                end else if (b == CH_LR) begin
                    o_burst = f_burst_byte(8'h0D);
                end else if (b == CH_LT) begin
                    o_burst = f_burst_byte(8'h09);
                end else if (b != CH_LU) begin
                    o_burst = f_burst_err(E_UNKNOWN_ESC);
                end
            end
            PH_HEX1, PH_HEX2: begin
                if (fin) begin
                    o_burst = f_burst_err(E_SHORT_UNI);
                end else if (!hex_ok) begin
                    o_burst = f_burst_err(E_BAD_HEX);
                end else if (r_hex_count == 2'd3) begin
                    if (r_phase == PH_HEX1) begin
                        if (lo_sur) begin
                            o_burst = f_burst_err(E_LONE_LOW);
                        end else if (!hi_sur) begin
                            o_burst = f_utf8({5'd0, cu_shift});
                        end
                    end else if (!lo_sur) begin
                        o_burst = f_burst_err(E_BAD_LOW);
                    end else begin
                        o_burst = f_utf8(pair_cp);
                    end
                end
            end
            PH_BSL: begin
                if (fin || b != CH_BSL) begin
                    o_burst = f_burst_err(E_NO_LOW);
                end
            end
            PH_LOWU: begin
                if (fin || b != CH_LU) begin
                    o_burst = f_burst_err(E_NO_LOW);
                end
            end
            default: begin
                if (fin || (!is_ws && b != CH_QUOTE)) begin
                    o_burst = f_burst_err(E_NO_QUOTE);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_code_unit <= 16'd0;
            r_high_half <= 10'd0;
            r_hex_count <= 2'd0;
        end else if (i_take) begin
            r_phase     <= n_phase;
            r_code_unit <= n_code_unit;
            r_high_half <= n_high_half;
            r_hex_count <= n_hex_count;
        end
    end

endmodule

// ----- rtl/core/jsu_emit.sv -----
// ----------------------------------------------------------------------------
// jsu_emit
// Result register; holds one burst and hands it out one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module jsu_emit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  jsu_pkg::t_burst i_burst,
    output logic            o_free,
    output logic            o_valid,
    input  logic            i_stall,
    output jsu_pkg::t_out   o_item
);
    import jsu_pkg::*;

    t_burst     r_burst;
    logic [2:0] r_cnt;
    logic [1:0] r_idx;
    logic       take;
    logic       at_last;

    assign o_valid = (r_cnt != 3'd0);
    assign take    = o_valid && !i_stall;
    assign at_last = (({1'b0, r_idx} + 3'd1) == r_cnt);
    assign o_free  = !o_valid || (take && at_last);

    always_comb begin
        o_item.out_kind   = r_burst.kind;
        o_item.out_byte   = r_burst.bytes[r_idx];
        o_item.error_code = r_burst.err;
        o_item.last       = at_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
            r_idx <= 2'd0;
        end else if (i_load && i_burst.count != 3'd0) begin
            r_cnt <= i_burst.count;
            r_idx <= 2'd0;
        end else if (take) begin
            if (at_last) begin
                r_cnt <= 3'd0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_burst <= i_burst;
        end
    end

endmodule
